FILE: hw/rtl/sftu_pkg.sv
// shared types and constants for the sprite frame texture coordinate unit
`timescale 1ns / 1ps

package sftu_pkg;

    // fixed point format of the coordinates: 2 integer bits over the fraction
    localparam int FRAC_BITS  = 16;
    localparam int QW         = FRAC_BITS + 2;

    // field widths
    localparam int SIZE_W     = 15;
    localparam int IDX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // bit-serial step counts
    localparam int DIV_STEPS  = IDX_W;
    localparam int MUL_STEPS  = IDX_W + 1;
    localparam int STEPS_MAX  = (QW > MUL_STEPS) ? QW : MUL_STEPS;
    localparam int CNT_W      = $clog2(STEPS_MAX);

    // item kinds
    typedef enum logic [1:0] {
        K_ADVANCE = 2'd0,
        K_JUMP    = 2'd1,
        K_SELECT  = 2'd2,
        K_QUERY   = 2'd3
    } t_kind;

    // result error codes
    typedef enum logic [1:0] {
        E_OK       = 2'd0,
        E_PAST_END = 2'd1,
        E_RANGE    = 2'd2,
        E_WIDE     = 2'd3
    } t_err;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEET_MODE      = 3'd0,
        REG_SPRITE_WIDTH    = 3'd1,
        REG_SPRITE_HEIGHT   = 3'd2,
        REG_TEXTURE_WIDTH   = 3'd3,
        REG_TEXTURE_HEIGHT  = 3'd4,
        REG_SPRITE_COUNT    = 3'd5,
        REG_FRAME_COUNT     = 3'd6,
        REG_ANIMATION_COUNT = 3'd7
    } t_cfg_reg;

    // input beat
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] index;
        logic [1:0]       corner;
    } t_in_item;

    // output beat
    typedef struct packed {
        t_err             error;
        logic [IDX_W-1:0] sprite_index;
        logic [QW-1:0]    tex_u;
        logic [QW-1:0]    tex_v;
    } t_out_item;

endpackage

FILE: hw/rtl/sprite_frame_texcoord_unit.sv
// sprite sheet frame tracker with bit-serial texture coordinate computation
// a new beat is stalled until the previous one has left the done state and its result is in
//   the output slot; a sprite wider than the texture goes from idle straight to the done state
// any other beat passes in order through the bit-serial units: two 16-step divisions,
//   a 17-step shift-and-add multiply and an 18-step fraction division
// reset: synchronous active low; configuration registers return to defaults, sprite and row to zero
`timescale 1ns / 1ps

module sprite_frame_texcoord_unit
    import sftu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_MUL  = 6'b001000,
        S_FDIV = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // configuration
    logic              r_mode;
    logic [SIZE_W-1:0] r_sw, r_sh, r_tw, r_th;
    logic [IDX_W-1:0]  r_scount, r_fcount, r_acount;

    // control and frame state
    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_cs, r_row;
    t_err              r_err;
    logic [1:0]        r_corner;
    logic              r_out_valid;
    t_out_item         r_out;

    // shared integer divider
    logic [SIZE_W-1:0] r_rem;
    logic [IDX_W-1:0]  r_quo;
    logic [IDX_W-1:0]  r_den;

    // multiply lanes
    logic [MUL_STEPS-1:0] r_xm, r_ym;
    logic [IDX_W:0]       r_xa, r_ya;
    logic                 r_xs, r_ys;

    // fraction divide lanes
    logic [SIZE_W-1:0] r_xr, r_yr;
    logic [QW-1:0]     r_xb, r_yb;

    // effective sizes and item front end
    logic [SIZE_W-1:0] sw_e, sh_e, tw_e, th_e;
    logic              is_wide;
    logic              in_acc;
    logic [IDX_W:0]    nxt;
    logic [IDX_W-1:0]  n_cs, n_row;
    t_err              n_err;

    // divider step
    logic [IDX_W-1:0]  dv_t;
    logic              dv_ge;
    logic [SIZE_W-1:0] dv_rem_n;
    logic [IDX_W-1:0]  dv_quo_n;
    logic [IDX_W-1:0]  row_sel;

    // multiply step
    logic [IDX_W+1:0]  x_sum, y_sum, x_lim, y_lim;
    logic              x_hit, y_hit;
    logic [IDX_W:0]    xa_n, ya_n;
    logic              xs_n, ys_n;

    // fraction divide step
    logic [IDX_W-1:0]  fx_t, fy_t;
    logic              fx_ge, fy_ge;
    logic [SIZE_W-1:0] xr_n, yr_n;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // zero sizes count as one
    assign sw_e    = (r_sw == '0) ? SIZE_W'(1) : r_sw;
    assign sh_e    = (r_sh == '0) ? SIZE_W'(1) : r_sh;
    assign tw_e    = (r_tw == '0) ? SIZE_W'(1) : r_tw;
    assign th_e    = (r_th == '0) ? SIZE_W'(1) : r_th;
    assign is_wide = (sw_e > tw_e);

    // frame state update for the incoming beat
    always_comb begin
        n_cs  = r_cs;
        n_row = r_row;
        n_err = E_OK;
        nxt   = {1'b0, r_cs} + (IDX_W+1)'(1);
        case (i_in_data.kind)
            K_ADVANCE: begin
                if (!r_mode) begin
                    if (nxt >= {1'b0, r_scount}) begin
                        n_err = E_PAST_END;
                    end else begin
                        n_cs = nxt[IDX_W-1:0];
                    end
                end else begin
                    n_cs = (nxt >= {1'b0, r_fcount}) ? '0 : nxt[IDX_W-1:0];
                end
            end
            K_JUMP: begin
                if (i_in_data.index >= r_scount) begin
                    n_err = E_RANGE;
                end else begin
                    n_cs = i_in_data.index;
                end
            end
            K_SELECT: begin
                if (i_in_data.index >= r_acount) begin
                    n_err = E_RANGE;
                end else begin
                    n_row = i_in_data.index;
                end
            end
            default: begin
            end
        endcase
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        dv_t     = {r_rem, r_quo[IDX_W-1]};
        dv_ge    = (dv_t >= r_den);
        dv_rem_n = dv_ge ? SIZE_W'(dv_t - r_den) : dv_t[SIZE_W-1:0];
        dv_quo_n = {r_quo[IDX_W-2:0], dv_ge};
        row_sel  = r_mode ? r_row : dv_quo_n;
    end

    // msb-first shift-and-add, sticky once the product reaches four texture sizes
    always_comb begin
        x_lim = {1'b0, tw_e, 2'b00};
        y_lim = {1'b0, th_e, 2'b00};
        x_sum = {r_xa, 1'b0} + (r_xm[MUL_STEPS-1] ? (IDX_W+2)'(sw_e) : '0);
        y_sum = {r_ya, 1'b0} + (r_ym[MUL_STEPS-1] ? (IDX_W+2)'(sh_e) : '0);
        x_hit = (x_sum >= x_lim);
        y_hit = (y_sum >= y_lim);
        xs_n  = r_xs || x_hit;
        ys_n  = r_ys || y_hit;
        xa_n  = xs_n ? r_xa : x_sum[IDX_W:0];
        ya_n  = ys_n ? r_ya : y_sum[IDX_W:0];
    end

    // fraction division by texture size, one bit per cycle per lane
    always_comb begin
        fx_t  = {r_xr, r_xb[QW-1]};
        fy_t  = {r_yr, r_yb[QW-1]};
        fx_ge = (fx_t >= {1'b0, tw_e});
        fy_ge = (fy_t >= {1'b0, th_e});
        xr_n  = fx_ge ? SIZE_W'(fx_t - {1'b0, tw_e}) : fx_t[SIZE_W-1:0];
        yr_n  = fy_ge ? SIZE_W'(fy_t - {1'b0, th_e}) : fy_t[SIZE_W-1:0];
    end

    // control, configuration and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cs        <= '0;
            r_row       <= '0;
            r_mode      <= 1'b0;
            r_sw        <= SIZE_W'(16);
            r_sh        <= SIZE_W'(16);
            r_tw        <= SIZE_W'(256);
            r_th        <= SIZE_W'(256);
            r_scount    <= IDX_W'(1);
            r_fcount    <= IDX_W'(1);
            r_acount    <= IDX_W'(1);
        end else begin
            // configuration beat
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_SHEET_MODE:      r_mode   <= i_cfg_data[0];
                    REG_SPRITE_WIDTH:    r_sw     <= i_cfg_data[SIZE_W-1:0];
                    REG_SPRITE_HEIGHT:   r_sh     <= i_cfg_data[SIZE_W-1:0];
                    REG_TEXTURE_WIDTH:   r_tw     <= i_cfg_data[SIZE_W-1:0];
                    REG_TEXTURE_HEIGHT:  r_th     <= i_cfg_data[SIZE_W-1:0];
                    REG_SPRITE_COUNT:    r_scount <= i_cfg_data;
                    REG_FRAME_COUNT:     r_fcount <= i_cfg_data;
                    REG_ANIMATION_COUNT: r_acount <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // output slot refills from the done state and drains when taken
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cs  <= n_cs;
                        r_row <= n_row;
                        r_state <= is_wide ? S_DONE : S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (r_cnt == CNT_W'(QW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath shift registers and step counter
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt    <= '0;
                r_err    <= is_wide ? E_WIDE : n_err;
                r_corner <= i_in_data.corner;
                // sprites per row: texture width over sprite width
                r_rem    <= '0;
                r_quo    <= IDX_W'(tw_e);
                r_den    <= IDX_W'(sw_e);
                // coordinates read as zero for a sprite wider than the texture
                r_xs     <= 1'b0;
                r_ys     <= 1'b0;
                r_xb     <= '0;
                r_yb     <= '0;
            end
            S_DIV1: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    // column and row: current sprite over sprites per row
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_quo <= r_cs;
                    r_den <= dv_quo_n;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_rem <= dv_rem_n;
                    r_quo <= dv_quo_n;
                end
            end
            S_DIV2: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    // right and bottom corners add one sprite size
                    r_cnt <= '0;
                    r_xm  <= MUL_STEPS'(dv_rem_n) + MUL_STEPS'(r_corner[0]);
                    r_ym  <= MUL_STEPS'(row_sel) + MUL_STEPS'(r_corner[1]);
                    r_xa  <= '0;
                    r_ya  <= '0;
                    r_xs  <= 1'b0;
                    r_ys  <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_rem <= dv_rem_n;
                    r_quo <= dv_quo_n;
                end
            end
            S_MUL: begin
                r_xm <= {r_xm[MUL_STEPS-2:0], 1'b0};
                r_ym <= {r_ym[MUL_STEPS-2:0], 1'b0};
                r_xa <= xa_n;
                r_ya <= ya_n;
                r_xs <= xs_n;
                r_ys <= ys_n;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    // product below four sizes: its top bits seed the remainder
                    r_cnt <= '0;
                    r_xr  <= xa_n[IDX_W:2];
                    r_yr  <= ya_n[IDX_W:2];
                    r_xb  <= {xa_n[1:0], {FRAC_BITS{1'b0}}};
                    r_yb  <= {ya_n[1:0], {FRAC_BITS{1'b0}}};
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            S_FDIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_xr  <= xr_n;
                r_yr  <= yr_n;
                r_xb  <= {r_xb[QW-2:0], fx_ge};
                r_yb  <= {r_yb[QW-2:0], fy_ge};
            end
            S_DONE: begin
                r_cnt <= '0;
                if (!r_out_valid || !i_out_stall) begin
                    r_out.error        <= r_err;
                    r_out.sprite_index <= r_cs;
                    r_out.tex_u        <= r_xs ? {QW{1'b1}} : r_xb;
                    r_out.tex_v        <= r_ys ? {QW{1'b1}} : r_yb;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule
